// ----- sv/usws_pkg.sv -----
// usws_pkg: shared types and codes for the unique stack with search
// no dependencies
`timescale 1ns / 1ps

package usws_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned OUT_W  = 6;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP_TO = 2'd1,
        OP_LOCATE = 2'd2,
        OP_COUNT  = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_DUP      = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

    // per-cell control broadcast from the sequencer
    typedef struct packed {
        logic cmp_en;
        logic wr_en;
    } t_cell_ctrl;

endpackage

// ----- sv/usws_cell.sv -----
// usws_cell: one stack slot, holds a word and its registered compare hit
// depends on usws_pkg
`timescale 1ns / 1ps

module usws_cell (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  usws_pkg::t_cell_ctrl                i_ctrl,
    input  logic                                i_live,
    input  logic signed [usws_pkg::WORD_W-1:0]  i_cmp_value,
    input  logic signed [usws_pkg::WORD_W-1:0]  i_wr_value,
    input  logic                                i_hit_above,
    output logic                                o_hit,
    output logic                                o_hit_chain
);

    logic signed [usws_pkg::WORD_W-1:0] r_entry;
    logic                               r_hit;

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_entry <= i_wr_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_ctrl.cmp_en) begin
            r_hit <= i_live && (r_entry == i_cmp_value);
        end
    end

    assign o_hit       = r_hit;
    // hit seen here or in any cell above
    assign o_hit_chain = r_hit | i_hit_above;

endmodule

// ----- sv/usws_enc.sv -----
// usws_enc: turns the one-hot hit row into the bottom-based slot index
// depends on nothing outside this file
`timescale 1ns / 1ps

module usws_enc #(
    parameter int unsigned DEPTH = 32
) (
    input  logic [DEPTH-1:0]         i_hits,
    output logic [$clog2(DEPTH)-1:0] o_index
);

    localparam int unsigned IDX_W = $clog2(DEPTH);

    // stack holds no duplicates, so at most one hit is set
    always_comb begin
        o_index = '0;
        for (int unsigned i = 0; i < DEPTH; i++) begin
            if (i_hits[i]) begin
                o_index = o_index | IDX_W'(i);
            end
        end
    end

endmodule

// ----- sv/unique_stack_with_search.sv -----
// unique_stack_with_search: bounded lifo of signed words with no duplicates
// depends on usws_pkg, usws_cell, usws_enc
//
// command channel: drive i_opcode and i_value with start high; the command
// is transferred at the rising edge where start is high and busy is low
// opcodes: push, pop down to value, locate value, report count
// every command returns exactly one result, shown for one cycle with
// o_valid high; o_status, o_position and o_depth are valid in that cycle
// the receiver cannot stall, so the result must be taken when shown
// timing: the transfer edge loads the command and every cell compares its
// word with the value at that same edge; in the cycle after, the hit row is
// encoded, and at its end the stack is updated and the result is registered
// busy stays high from the transfer until the result cycle, so a new command
// can be transferred in the cycle its result is shown; the command spacing
// is set by the compare-then-encode pass over the cell row
// the row of cells grows with DEPTH; the encode is an or tree over DEPTH
// reset (i_rst_n low, synchronous) empties the stack and clears busy and
// o_valid; stored words are not cleared, only slots below the depth count
// take part in compares
`timescale 1ns / 1ps

module unique_stack_with_search #(
    parameter int unsigned DEPTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          i_opcode,
    input  logic signed [usws_pkg::WORD_W-1:0]  i_value,
    output logic                                o_valid,
    output logic [2:0]                          o_status,
    output logic [usws_pkg::OUT_W-1:0]          o_position,
    output logic [usws_pkg::OUT_W-1:0]          o_depth
);

    localparam int unsigned IDX_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    // control state
    logic                r_busy;
    logic                r_valid;
    logic [CNT_W-1:0]    r_depth;
    logic [CNT_W-1:0]    n_depth;

    // command held during the encode cycle
    usws_pkg::t_opcode                  r_opcode;
    logic signed [usws_pkg::WORD_W-1:0] r_value;

    // result registers
    usws_pkg::t_status        r_status;
    usws_pkg::t_status        n_status;
    logic [CNT_W-1:0]         r_position;
    logic [CNT_W-1:0]         n_position;

    logic                  accept;
    logic [DEPTH-1:0]      hits;
    logic [DEPTH:0]        hit_chain;
    logic [IDX_W-1:0]      hit_index;
    logic                  found;
    logic                  do_push;
    logic                  do_pop;

    assign accept = start && !r_busy;

    // hit flags ripple down from the top cell; the bottom output says any hit
    assign hit_chain[DEPTH] = 1'b0;
    assign found            = hit_chain[0];

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            usws_pkg::t_cell_ctrl ctrl;
            logic                 live;

            assign ctrl.cmp_en = accept;
            // push writes the slot just above the current top
            assign ctrl.wr_en  = do_push && (r_depth == CNT_W'(g));
            assign live        = CNT_W'(g) < r_depth;

            usws_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctrl      (ctrl),
                .i_live      (live),
                .i_cmp_value (i_value),
                .i_wr_value  (r_value),
                .i_hit_above (hit_chain[g+1]),
                .o_hit       (hits[g]),
                .o_hit_chain (hit_chain[g])
            );
        end
    endgenerate

    usws_enc #(
        .DEPTH (DEPTH)
    ) u_enc (
        .i_hits  (hits),
        .o_index (hit_index)
    );

    // decide the result in the encode cycle
    always_comb begin
        n_status   = usws_pkg::ST_OK;
        n_position = '0;
        n_depth    = r_depth;
        do_push    = 1'b0;
        do_pop     = 1'b0;
        case (r_opcode)
            usws_pkg::OP_PUSH: begin
                // full takes priority over duplicate
                if (r_depth >= CNT_W'(DEPTH)) begin
                    n_status = usws_pkg::ST_FULL;
                end else if (found) begin
                    n_status = usws_pkg::ST_DUP;
                end else begin
                    do_push = 1'b1;
                    n_depth = r_depth + CNT_W'(1);
                end
            end
            usws_pkg::OP_POP_TO, usws_pkg::OP_LOCATE: begin
                if (r_depth == '0) begin
                    n_status = usws_pkg::ST_EMPTY;
                end else if (!found) begin
                    n_status = usws_pkg::ST_NOTFOUND;
                end else begin
                    n_position = r_depth - CNT_W'(hit_index);
                    if (r_opcode == usws_pkg::OP_POP_TO) begin
                        do_pop  = 1'b1;
                        n_depth = CNT_W'(hit_index);
                    end
                end
            end
            usws_pkg::OP_COUNT: begin
                n_status = usws_pkg::ST_OK;
            end
            default: begin
                n_status = usws_pkg::ST_OK;
            end
        endcase
        if (!r_busy) begin
            do_push = 1'b0;
            do_pop  = 1'b0;
            n_depth = r_depth;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
            r_depth <= '0;
        end else begin
            r_valid <= r_busy;
            if (accept) begin
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_busy <= 1'b0;
            end
            if (do_push || do_pop) begin
                r_depth <= n_depth;
            end
        end
    end

    // command and result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_opcode <= usws_pkg::t_opcode'(i_opcode);
            r_value  <= i_value;
        end
        if (r_busy) begin
            r_status   <= n_status;
            r_position <= n_position;
        end
    end

    assign busy       = r_busy;
    assign o_valid    = r_valid;
    assign o_status   = r_status;
    // wide depths wrap in the 6-bit result fields
    assign o_position = usws_pkg::OUT_W'(r_position);
    assign o_depth    = usws_pkg::OUT_W'(r_depth);

endmodule

// ----- dv/tb_unique_stack_with_search.sv -----
// tb_unique_stack_with_search: self-checking bench for the unique stack with search
// depends on usws_pkg and unique_stack_with_search; a directed table, then random
// fill / churn / noise phases checked against a behavioral stack inside the bench
`timescale 1ns / 1ps

module tb_unique_stack_with_search;

    localparam int unsigned STACK_DEPTH    = 32;
    localparam int unsigned RANDOM_ITEMS   = 1350;
    localparam int unsigned RESULT_LATENCY = 2;
    localparam int unsigned CYCLE_LIMIT    = 200000;
    localparam int unsigned IDLE_PERCENT   = 26;
    localparam int unsigned N_DIRECTED     = 23;

    localparam logic [31:0] VAL_MIN  = 32'h8000_0000;
    localparam logic [31:0] VAL_MAX  = 32'h7fff_ffff;
    localparam logic [31:0] VAL_ZERO = 32'h0000_0000;
    localparam logic [31:0] VAL_NEG1 = 32'hffff_ffff;

    // one result as seen on the output ports
    typedef struct packed {
        usws_pkg::t_status status;
        logic [5:0]        position;
        logic [5:0]        depth;
    } t_stack_result;

    // one row of the directed table; typed rows carry their own expected result
    typedef struct packed {
        usws_pkg::t_opcode op;
        logic [31:0]       val;
        logic              typed;
        t_stack_result     res;
    } t_cmd_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_opcode;
    logic [31:0] i_value;
    logic        o_valid;
    logic [2:0]  o_status;
    logic [5:0]  o_position;
    logic [5:0]  o_depth;

    // behavioral copy of the stack, entry 0 at the bottom
    logic [31:0]   model_words [STACK_DEPTH];
    int unsigned   model_count;

    t_stack_result expected_results [$];
    int unsigned   mismatch_count;
    int unsigned   cycle_count;
    int unsigned   items_sent;

    // directed table: extremes, every opcode, empty / duplicate / missing cases
    t_cmd_row directed_rows [N_DIRECTED] = '{
        '{usws_pkg::OP_COUNT,  VAL_ZERO, 1'b1, '{usws_pkg::ST_OK,       6'd0, 6'd0}},
        '{usws_pkg::OP_POP_TO, VAL_ZERO, 1'b1, '{usws_pkg::ST_EMPTY,    6'd0, 6'd0}},
        '{usws_pkg::OP_LOCATE, VAL_MIN,  1'b1, '{usws_pkg::ST_EMPTY,    6'd0, 6'd0}},
        '{usws_pkg::OP_PUSH,   VAL_MIN,  1'b1, '{usws_pkg::ST_OK,       6'd0, 6'd1}},
        '{usws_pkg::OP_PUSH,   VAL_MAX,  1'b1, '{usws_pkg::ST_OK,       6'd0, 6'd2}},
        '{usws_pkg::OP_PUSH,   VAL_MAX,  1'b1, '{usws_pkg::ST_DUP,      6'd0, 6'd2}},
        '{usws_pkg::OP_PUSH,   VAL_MIN,  1'b1, '{usws_pkg::ST_DUP,      6'd0, 6'd2}},
        '{usws_pkg::OP_LOCATE, VAL_MIN,  1'b1, '{usws_pkg::ST_OK,       6'd2, 6'd2}},
        '{usws_pkg::OP_LOCATE, VAL_MAX,  1'b1, '{usws_pkg::ST_OK,       6'd1, 6'd2}},
        '{usws_pkg::OP_LOCATE, VAL_ZERO, 1'b1, '{usws_pkg::ST_NOTFOUND, 6'd0, 6'd2}},
        '{usws_pkg::OP_POP_TO, VAL_NEG1, 1'b1, '{usws_pkg::ST_NOTFOUND, 6'd0, 6'd2}},
        '{usws_pkg::OP_PUSH,   VAL_ZERO,      1'b0, '0},
        '{usws_pkg::OP_PUSH,   VAL_NEG1,      1'b0, '0},
        '{usws_pkg::OP_PUSH,   32'h1,         1'b0, '0},
        '{usws_pkg::OP_COUNT,  VAL_NEG1,      1'b0, '0},
        '{usws_pkg::OP_POP_TO, VAL_ZERO,      1'b0, '0},
        '{usws_pkg::OP_LOCATE, 32'h1,         1'b0, '0},
        '{usws_pkg::OP_POP_TO, VAL_MIN,       1'b0, '0},
        '{usws_pkg::OP_COUNT,  VAL_ZERO,      1'b0, '0},
        '{usws_pkg::OP_PUSH,   32'h5555_5555, 1'b0, '0},
        '{usws_pkg::OP_PUSH,   32'haaaa_aaaa, 1'b0, '0},
        '{usws_pkg::OP_POP_TO, 32'haaaa_aaaa, 1'b0, '0},
        '{usws_pkg::OP_POP_TO, 32'h5555_5555, 1'b0, '0}
    };

    unique_stack_with_search #(
        .DEPTH(STACK_DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_opcode   (i_opcode),
        .i_value    (i_value),
        .o_valid    (o_valid),
        .o_status   (o_status),
        .o_position (o_position),
        .o_depth    (o_depth)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // watchdog on the whole run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int unsigned exp_v,
                                   input int unsigned got_v);
        $display("[%0t] mismatch %s: expected %0d got %0d", $realtime, what, exp_v, got_v);
        mismatch_count++;
    endtask

    // predict one command and apply it to the behavioral stack
    task automatic predict_stack_op(input logic [1:0] op, input logic [31:0] val,
                                    output t_stack_result res);
        int found_at;
        found_at = -1;
        for (int i = 0; i < int'(model_count); i++) begin
            if (found_at < 0 && model_words[i] == val)
                found_at = i;
        end
        res.status   = usws_pkg::ST_OK;
        res.position = '0;
        case (usws_pkg::t_opcode'(op))
            usws_pkg::OP_PUSH: begin
                // full wins over duplicate
                if (model_count >= STACK_DEPTH) begin
                    res.status = usws_pkg::ST_FULL;
                end else if (found_at >= 0) begin
                    res.status = usws_pkg::ST_DUP;
                end else begin
                    model_words[model_count] = val;
                    model_count++;
                end
            end
            usws_pkg::OP_POP_TO: begin
                if (model_count == 0) begin
                    res.status = usws_pkg::ST_EMPTY;
                end else if (found_at < 0) begin
                    res.status = usws_pkg::ST_NOTFOUND;
                end else begin
                    res.position = 6'(model_count - found_at);
                    model_count  = found_at;
                end
            end
            usws_pkg::OP_LOCATE: begin
                if (model_count == 0)
                    res.status = usws_pkg::ST_EMPTY;
                else if (found_at < 0)
                    res.status = usws_pkg::ST_NOTFOUND;
                else
                    res.position = 6'(model_count - found_at);
            end
            default: ;
        endcase
        res.depth = 6'(model_count);
    endtask

    // drive one command, hold it until the transfer, queue its expected result
    task automatic send_command(input logic [1:0] op, input logic [31:0] val,
                                input logic use_typed, input t_stack_result typed_res);
        t_stack_result predicted;
        start    = 1'b1;
        i_opcode = op;
        i_value  = val;
        do @(posedge i_clk); while (busy !== 1'b0);
        predict_stack_op(op, val, predicted);
        expected_results.push_back(use_typed ? typed_res : predicted);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_checked(input logic [1:0] op, input logic [31:0] val);
        send_command(op, val, 1'b0, '0);
    endtask

    // random idle on the command side; a long stretch in the middle runs back to back
    task automatic maybe_idle();
        if (items_sent >= N_DIRECTED + 500 && items_sent < N_DIRECTED + 800)
            return;
        if ($urandom_range(0, 99) < IDLE_PERCENT) begin
            start = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
    endtask

    // hold commands off until every outstanding result has come back
    task automatic drain_results();
        start = 1'b0;
        while (expected_results.size() != 0)
            @(negedge i_clk);
    endtask

    // operands lean toward values on the stack so hits are common
    function automatic logic [31:0] pick_operand();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45 && model_count > 0)
            return model_words[$urandom_range(0, model_count - 1)];
        if (r < 65)
            return 32'($signed($urandom_range(0, 15)) - 8);
        if (r < 75) begin
            case ($urandom_range(0, 3))
                0:       return VAL_MIN;
                1:       return VAL_MAX;
                2:       return VAL_ZERO;
                default: return VAL_NEG1;
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic [1:0] pick_opcode();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return usws_pkg::OP_PUSH;
        if (r < 55)
            return usws_pkg::OP_POP_TO;
        if (r < 90)
            return usws_pkg::OP_LOCATE;
        return usws_pkg::OP_COUNT;
    endfunction

    // push fresh words to the top, then hit the full cases and the bottom entry
    task automatic fill_phase();
        while (model_count < STACK_DEPTH) begin
            send_checked(usws_pkg::OP_PUSH, $urandom);
            maybe_idle();
        end
        // full with the value already present, then a fresh value
        send_checked(usws_pkg::OP_PUSH, model_words[$urandom_range(0, STACK_DEPTH - 1)]);
        maybe_idle();
        send_checked(usws_pkg::OP_PUSH, $urandom);
        maybe_idle();
        send_checked(usws_pkg::OP_LOCATE, model_words[0]);
        maybe_idle();
        if ($urandom_range(0, 1) == 0)
            send_checked(usws_pkg::OP_POP_TO, model_words[0]);
        else
            send_checked(usws_pkg::OP_POP_TO,
                         model_words[$urandom_range(0, STACK_DEPTH - 1)]);
        maybe_idle();
    endtask

    task automatic churn_phase();
        repeat ($urandom_range(20, 60)) begin
            send_checked(pick_opcode(), pick_operand());
            maybe_idle();
        end
    endtask

    // unweighted opcode and value
    task automatic noise_phase();
        repeat ($urandom_range(10, 20)) begin
            send_checked(2'($urandom), $urandom);
            maybe_idle();
        end
    endtask

    // result side: every strobe must match the oldest expectation
    always @(posedge i_clk) begin
        t_stack_result exp_r;
        if (o_valid === 1'b1) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result, status", 0, o_status);
            end else begin
                exp_r = expected_results.pop_front();
                if (o_status !== exp_r.status)
                    report_mismatch("status", exp_r.status, o_status);
                if (o_position !== exp_r.position)
                    report_mismatch("position", exp_r.position, o_position);
                if (o_depth !== exp_r.depth)
                    report_mismatch("depth", exp_r.depth, o_depth);
            end
        end
    end

    initial begin
        int unsigned phase_no;
        int unsigned pick;
        start          = 1'b0;
        i_opcode       = usws_pkg::OP_PUSH;
        i_value        = '0;
        i_rst_n        = 1'b0;
        model_count    = 0;
        mismatch_count = 0;
        cycle_count    = 0;
        items_sent     = 0;
        phase_no       = 0;
        for (int i = 0; i < STACK_DEPTH; i++)
            model_words[i] = '0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed table
        foreach (directed_rows[i]) begin
            send_command(directed_rows[i].op, directed_rows[i].val,
                         directed_rows[i].typed, directed_rows[i].res);
            maybe_idle();
        end
        drain_results();

        // random part: first phase always fills the stack
        fill_phase();
        while (items_sent < N_DIRECTED + RANDOM_ITEMS) begin
            phase_no++;
            if (phase_no % 10 == 0)
                drain_results();
            pick = $urandom_range(0, 7);
            if (pick < 2)
                fill_phase();
            else if (pick < 7)
                churn_phase();
            else
                noise_phase();
        end

        // wait out the last results, then keep watching for stray strobes
        drain_results();
        repeat (RESULT_LATENCY + 4) @(posedge i_clk);
        if (expected_results.size() != 0)
            report_mismatch("results left over", 0, expected_results.size());

        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
